@@ rtl/bbwm_pkg.sv @@
// bbwm_pkg: shared types and constants of the billboard world matrix block
// transaction structs, queue entry, row bundle and back-end state codes; no dependencies
package bbwm_pkg;

    // exact width of a position difference
    localparam int DIFF_W      = 33;
    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // matrix row codes
    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_BACK  = 2'd2;
    localparam logic [1:0] ROW_POS   = 2'd3;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] billboard_x;
        logic signed [31:0] billboard_y;
        logic signed [31:0] billboard_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
    } bbwm_in_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] elem_x;
        logic signed [31:0] elem_y;
        logic signed [31:0] elem_z;
        logic               degenerate;
        logic               last;
    } bbwm_out_t;

    typedef enum logic [1:0] {
        JOB_NORMAL,
        JOB_CYL_ZERO,
        JOB_DEGEN
    } bbwm_kind_t;

    typedef struct packed {
        bbwm_kind_t                kind;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  dz;
        logic signed [31:0]        sx;
        logic signed [31:0]        sy;
        logic signed [31:0]        px;
        logic signed [31:0]        py;
        logic signed [31:0]        pz;
    } bbwm_job_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } bbwm_vec_t;

    typedef struct packed {
        bbwm_vec_t [3:0] row;
        logic            degenerate;
    } bbwm_rows_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_NORM,
        BK_SQ,
        BK_SQRT,
        BK_DSET,
        BK_DIV,
        BK_MUL,
        BK_PUSH
    } bbwm_bk_state_t;

endpackage

@@ rtl/billboard_world_matrix.sv @@
// billboard_world_matrix: top level of the billboard orientation matrix block
// uses bbwm_pkg; instantiates bbwm_front, bbwm_queue, bbwm_back and bbwm_emit
//
// Each input transaction (mode, camera, billboard centre, two scales, all signed
// fixed point with FRAC_BITS fraction bits) yields four result transactions, the
// rows of the row-major world matrix in order: sx*right, sy*up', -forward and the
// billboard position, last set on the fourth. The front takes a transaction in
// any cycle the two-entry job queue has room, forms the exact 33-bit difference
// and flags the zero-direction cases. The back works one job at a time in steps:
// normalizing shifts, squaring, a bit-serial square root, three-lane bit-serial
// division, products on one shared multiplier and a hand-off to the row buffer; a
// zero-direction job goes straight to the multiplier steps. The square root and
// the division set the sustained rate. The four rows drain from their own buffer,
// one per cycle whenever the receiver is ready, and the back meanwhile already
// works on the next job. Reset is synchronous, active low; no configuration.
module billboard_world_matrix
    import bbwm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bbwm_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output bbwm_out_t m_data
);

    // front to queue
    logic       q_push;
    bbwm_job_t  q_push_data;
    logic       q_full;
    // queue to back
    logic       q_pop;
    bbwm_job_t  q_pop_data;
    logic       q_empty;
    // back to row buffer
    logic       rows_push;
    bbwm_rows_t rows_data;
    logic       rows_ready;

    // difference and classification
    bbwm_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_data  (q_push_data),
        .q_full  (q_full)
    );

    // decouples acceptance from the long back-end computation
    bbwm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // normalize, cross products and scaling
    bbwm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_data     (q_pop_data),
        .rows_push  (rows_push),
        .rows_data  (rows_data),
        .rows_ready (rows_ready)
    );

    // one row per result transaction
    bbwm_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rows_push),
        .rows_data (rows_data),
        .ready     (rows_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ rtl/bbwm_front.sv @@
// bbwm_front: input side, forms camera minus billboard and classifies the transaction
// uses bbwm_pkg; feeds bbwm_queue
module bbwm_front
    import bbwm_pkg::*;
(
    input  logic      s_valid,
    output logic      s_ready,
    input  bbwm_in_t  s_data,
    output logic      q_push,
    output bbwm_job_t q_data,
    input  logic      q_full
);

    logic signed [DIFF_W-1:0] dx, dy, dz;

    always_comb begin
        dx = {s_data.cam_x[31], s_data.cam_x} - {s_data.billboard_x[31], s_data.billboard_x};
        dz = {s_data.cam_z[31], s_data.cam_z} - {s_data.billboard_z[31], s_data.billboard_z};
        // cylindrical mode drops the vertical part
        if (s_data.mode) begin
            dy = {s_data.cam_y[31], s_data.cam_y} - {s_data.billboard_y[31], s_data.billboard_y};
        end else begin
            dy = '0;
        end
    end

    always_comb begin
        q_data.dx = dx;
        q_data.dy = dy;
        q_data.dz = dz;
        q_data.sx = s_data.scale_x;
        q_data.sy = s_data.scale_y;
        q_data.px = s_data.billboard_x;
        q_data.py = s_data.billboard_y;
        q_data.pz = s_data.billboard_z;
        priority if (dx != '0 || dy != '0 || dz != '0) begin
            q_data.kind = JOB_NORMAL;
        end else if (s_data.mode) begin
            q_data.kind = JOB_DEGEN;
        end else begin
            q_data.kind = JOB_CYL_ZERO;
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

@@ rtl/bbwm_queue.sv @@
// bbwm_queue: short queue of classified jobs between front and back
// uses bbwm_pkg for the entry type and depth
module bbwm_queue
    import bbwm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  bbwm_job_t push_data,
    output logic      full,
    input  logic      pop,
    output bbwm_job_t pop_data,
    output logic      empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bbwm_job_t        entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/bbwm_back.sv @@
// bbwm_back: normalizes the direction and builds the matrix rows of one job
// uses bbwm_pkg; bit-serial square root and division, one shared multiplier
module bbwm_back
    import bbwm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    output logic       q_pop,
    input  bbwm_job_t  q_data,
    output logic       rows_push,
    output bbwm_rows_t rows_data,
    input  logic       rows_ready
);

    localparam int F    = FRAC_BITS;
    localparam int QW   = F + 1;      // unit component magnitude
    localparam int FW   = F + 2;      // signed unit component
    localparam int UW   = F + 2;      // up' component magnitude
    localparam int UPW  = F + 3;      // signed up' component
    localparam int BW   = F + 2;      // multiplier b operand
    localparam int PW   = 32 + BW;    // product
    localparam int AW   = PW + 1;     // product sum
    localparam int RW   = AW - F;     // rounded product
    localparam int DVW  = F + 32;     // dividend and shifted divisor
    localparam int CNTW = $clog2(F + 1);

    localparam logic [AW-1:0] HALF = AW'(1) << (F - 1);
    localparam logic signed [FW-1:0] ONE_Q = FW'(1) << F;

    bbwm_bk_state_t state_reg, state_next;
    bbwm_job_t      job_reg, job_next;

    logic [DIFF_W-1:0]      m_reg [3], m_next [3];
    logic [1:0]             sq_cnt_reg, sq_cnt_next;
    logic [61:0]            sq_reg, sq_next;
    logic [63:0]            acc_reg, acc_next;
    logic [63:0]            n_reg, n_next, res_reg, res_next, bit_reg, bit_next;
    logic [DVW-1:0]         rem_reg [3], rem_next [3];
    logic [DVW-1:0]         dsh_reg, dsh_next;
    logic [QW-1:0]          q_reg [3], q_next [3];
    logic [CNTW-1:0]        div_cnt_reg, div_cnt_next;
    logic signed [FW-1:0]   f_reg [3], f_next [3];
    logic [3:0]             mul_cnt_reg, mul_cnt_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic                   prod_neg_reg, prod_neg_next;
    logic [AW-1:0]          up1_acc_reg, up1_acc_next;
    logic signed [UPW-1:0]  up_reg [3], up_next [3];
    logic signed [31:0]     row0_reg [2], row0_next [2];
    logic signed [31:0]     row1_reg [3], row1_next [3];

    logic [DIFF_W-1:0]        mx;
    logic                     norm_ok;
    logic signed [DIFF_W-1:0] d_in [3], d_job [3];
    logic [QW-1:0]            f_mag [3];
    logic [2:0]               f_neg, f_pos;
    logic [UW-1:0]            up_mag [3];
    logic [2:0]               up_neg;
    logic [31:0]              sx_mag, sy_mag;
    logic [31:0]              mul_a;
    logic [BW-1:0]            mul_b;
    logic                     mul_neg;
    logic [RW-1:0]            prod_rnd;

    function automatic logic [RW-1:0] rnd(input logic [AW-1:0] x);
        logic [AW-1:0] t;
        t = x + HALF;
        return t[AW-1:F];
    endfunction

    function automatic logic signed [31:0] sat(input logic [RW-1:0] mag, input logic neg);
        logic [RW-1:0] t;
        t = -mag;
        if (!neg) begin
            return (mag > RW'(32'h7fff_ffff)) ? 32'sh7fff_ffff : mag[31:0];
        end else if (mag > RW'(32'h8000_0000)) begin
            return 32'sh8000_0000;
        end else begin
            return t[31:0];
        end
    endfunction

    // operand views
    always_comb begin
        d_in[0]  = q_data.dx;
        d_in[1]  = q_data.dy;
        d_in[2]  = q_data.dz;
        d_job[0] = job_reg.dx;
        d_job[1] = job_reg.dy;
        d_job[2] = job_reg.dz;
        for (int i = 0; i < 3; i++) begin
            f_neg[i]  = f_reg[i][FW-1];
            f_pos[i]  = !f_reg[i][FW-1] && (f_reg[i] != '0);
            f_mag[i]  = f_neg[i] ? QW'(-f_reg[i]) : QW'(f_reg[i]);
            up_neg[i] = up_reg[i][UPW-1];
            up_mag[i] = up_neg[i] ? UW'(-up_reg[i]) : UW'(up_reg[i]);
        end
        sx_mag = job_reg.sx[31] ? 32'(-job_reg.sx) : 32'(job_reg.sx);
        sy_mag = job_reg.sy[31] ? 32'(-job_reg.sy) : 32'(job_reg.sy);
        mx = m_reg[0];
        if (m_reg[1] > mx) mx = m_reg[1];
        if (m_reg[2] > mx) mx = m_reg[2];
        norm_ok  = (mx[DIFF_W-1:30] == 3'b001);
        prod_rnd = rnd({1'b0, prod_reg});
    end

    // multiplier operand select, one product per step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (mul_cnt_reg)
            4'd0: begin
                mul_a = 32'(f_mag[0]); mul_b = BW'(f_mag[1]); mul_neg = !(f_neg[0] ^ f_neg[1]);
            end
            4'd1: begin
                mul_a = 32'(f_mag[0]); mul_b = BW'(f_mag[0]);
            end
            4'd2: begin
                mul_a = 32'(f_mag[2]); mul_b = BW'(f_mag[2]);
            end
            4'd3: begin
                mul_a = 32'(f_mag[1]); mul_b = BW'(f_mag[2]); mul_neg = !(f_neg[1] ^ f_neg[2]);
            end
            4'd4: begin
                mul_a = sx_mag; mul_b = BW'(f_mag[2]); mul_neg = job_reg.sx[31] ^ f_neg[2];
            end
            4'd5: begin
                mul_a = sx_mag; mul_b = BW'(f_mag[0]); mul_neg = job_reg.sx[31] ^ f_pos[0];
            end
            4'd6: begin
                mul_a = sy_mag; mul_b = up_mag[0]; mul_neg = job_reg.sy[31] ^ up_neg[0];
            end
            4'd7: begin
                mul_a = sy_mag; mul_b = up_mag[1]; mul_neg = job_reg.sy[31] ^ up_neg[1];
            end
            4'd8: begin
                mul_a = sy_mag; mul_b = up_mag[2]; mul_neg = job_reg.sy[31] ^ up_neg[2];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    state_next = (q_data.kind == JOB_NORMAL) ? BK_NORM : BK_MUL;
                end
            end
            BK_NORM: if (norm_ok) state_next = BK_SQ;
            BK_SQ:   if (sq_cnt_reg == 2'd3) state_next = BK_SQRT;
            BK_SQRT: if (bit_reg == 64'd1) state_next = BK_DSET;
            BK_DSET: state_next = BK_DIV;
            BK_DIV:  if (div_cnt_reg == CNTW'(F)) state_next = BK_MUL;
            BK_MUL:  if (mul_cnt_reg == 4'd9) state_next = BK_PUSH;
            BK_PUSH: if (rows_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_pop     = (state_reg == BK_IDLE) && !q_empty;
        rows_push = (state_reg == BK_PUSH) && rows_ready;
    end

    always_comb begin
        logic [61:0]    m_sel;
        logic [63:0]    trial;
        logic [2:0]     qb;
        logic [31:0]    len;
        logic [QW-1:0]  qn;

        job_next      = job_reg;
        sq_cnt_next   = sq_cnt_reg;
        sq_next       = sq_reg;
        acc_next      = acc_reg;
        n_next        = n_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        dsh_next      = dsh_reg;
        div_cnt_next  = div_cnt_reg;
        mul_cnt_next  = mul_cnt_reg;
        prod_next     = prod_reg;
        prod_neg_next = prod_neg_reg;
        up1_acc_next  = up1_acc_reg;
        m_sel         = '0;
        trial         = res_reg + bit_reg;
        qb            = '0;
        len           = res_reg[31:0];
        qn            = '0;
        for (int i = 0; i < 3; i++) begin
            m_next[i]   = m_reg[i];
            rem_next[i] = rem_reg[i];
            q_next[i]   = q_reg[i];
            f_next[i]   = f_reg[i];
            up_next[i]  = up_reg[i];
            row1_next[i] = row1_reg[i];
        end
        for (int i = 0; i < 2; i++) begin
            row0_next[i] = row0_reg[i];
        end

        unique case (state_reg)
            BK_IDLE: begin
                sq_cnt_next  = '0;
                mul_cnt_next = '0;
                if (!q_empty) begin
                    job_next = q_data;
                    for (int i = 0; i < 3; i++) begin
                        m_next[i] = d_in[i][DIFF_W-1] ? DIFF_W'(-d_in[i]) : DIFF_W'(d_in[i]);
                    end
                    unique case (q_data.kind)
                        JOB_CYL_ZERO: begin
                            f_next[0] = '0;
                            f_next[1] = '0;
                            f_next[2] = ONE_Q;
                        end
                        JOB_DEGEN: begin
                            for (int i = 0; i < 3; i++) f_next[i] = '0;
                        end
                        default: begin
                            f_next[0] = f_reg[0];
                        end
                    endcase
                end
            end
            BK_NORM: begin
                // bring the largest magnitude into [2^30, 2^31)
                priority if (mx[DIFF_W-1:31] != '0) begin
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] >> 1;
                end else if (mx[DIFF_W-1:22] == '0) begin
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] << 8;
                end else if (!mx[30]) begin
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] << 1;
                end
            end
            BK_SQ: begin
                unique case (sq_cnt_reg)
                    2'd0:    m_sel = 62'(m_reg[0][30:0]);
                    2'd1:    m_sel = 62'(m_reg[1][30:0]);
                    default: m_sel = 62'(m_reg[2][30:0]);
                endcase
                sq_next     = m_sel * m_sel;
                acc_next    = (sq_cnt_reg == 2'd0) ? 64'd0 : acc_reg + 64'(sq_reg);
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == 2'd3) begin
                    n_next   = acc_reg + 64'(sq_reg);
                    res_next = '0;
                    bit_next = 64'd1 << 62;
                end
            end
            BK_SQRT: begin
                if (n_reg >= trial) begin
                    n_next   = n_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            BK_DSET: begin
                for (int i = 0; i < 3; i++) begin
                    rem_next[i] = {1'b0, m_reg[i][30:0], {F{1'b0}}}
                                + {{F{1'b0}}, 1'b0, len[31:1]};
                    q_next[i]   = '0;
                end
                dsh_next     = {len, {F{1'b0}}};
                div_cnt_next = '0;
            end
            BK_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (rem_reg[i] >= dsh_reg) begin
                        rem_next[i] = rem_reg[i] - dsh_reg;
                        qb[i]       = 1'b1;
                    end
                    q_next[i] = {q_reg[i][QW-2:0], qb[i]};
                    if (div_cnt_reg == CNTW'(F)) begin
                        qn        = q_next[i];
                        f_next[i] = d_job[i][DIFF_W-1] ? -$signed({1'b0, qn})
                                                       : $signed({1'b0, qn});
                    end
                end
                dsh_next     = dsh_reg >> 1;
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            BK_MUL: begin
                prod_next     = {{(PW-32){1'b0}}, mul_a} * {{(PW-BW){1'b0}}, mul_b};
                prod_neg_next = mul_neg;
                mul_cnt_next  = mul_cnt_reg + 1'b1;
                // consume the product registered at the previous step
                unique case (mul_cnt_reg)
                    4'd1: up_next[0] = prod_neg_reg ? -$signed({1'b0, prod_rnd[UW-1:0]})
                                                    : $signed({1'b0, prod_rnd[UW-1:0]});
                    4'd2: up1_acc_next = {1'b0, prod_reg};
                    4'd3: up_next[1] = $signed({1'b0, UW'(rnd(up1_acc_reg + {1'b0, prod_reg}))});
                    4'd4: up_next[2] = prod_neg_reg ? -$signed({1'b0, prod_rnd[UW-1:0]})
                                                    : $signed({1'b0, prod_rnd[UW-1:0]});
                    4'd5: row0_next[0] = sat(prod_rnd, prod_neg_reg);
                    4'd6: row0_next[1] = sat(prod_rnd, prod_neg_reg);
                    4'd7: row1_next[0] = sat(prod_rnd, prod_neg_reg);
                    4'd8: row1_next[1] = sat(prod_rnd, prod_neg_reg);
                    4'd9: row1_next[2] = sat(prod_rnd, prod_neg_reg);
                    default: up1_acc_next = up1_acc_reg;
                endcase
            end
            BK_PUSH: begin
                mul_cnt_next = '0;
            end
            default: begin
                mul_cnt_next = '0;
            end
        endcase
    end

    always_comb begin
        logic signed [FW-1:0] nf [3];
        for (int i = 0; i < 3; i++) nf[i] = -f_reg[i];
        rows_data.row[ROW_RIGHT].x = row0_reg[0];
        rows_data.row[ROW_RIGHT].y = '0;
        rows_data.row[ROW_RIGHT].z = row0_reg[1];
        rows_data.row[ROW_UP].x    = row1_reg[0];
        rows_data.row[ROW_UP].y    = row1_reg[1];
        rows_data.row[ROW_UP].z    = row1_reg[2];
        rows_data.row[ROW_BACK].x  = {{(32-FW){nf[0][FW-1]}}, nf[0]};
        rows_data.row[ROW_BACK].y  = {{(32-FW){nf[1][FW-1]}}, nf[1]};
        rows_data.row[ROW_BACK].z  = {{(32-FW){nf[2][FW-1]}}, nf[2]};
        rows_data.row[ROW_POS].x   = job_reg.px;
        rows_data.row[ROW_POS].y   = job_reg.py;
        rows_data.row[ROW_POS].z   = job_reg.pz;
        rows_data.degenerate       = (job_reg.kind == JOB_DEGEN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        sq_cnt_reg   <= sq_cnt_next;
        sq_reg       <= sq_next;
        acc_reg      <= acc_next;
        n_reg        <= n_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        dsh_reg      <= dsh_next;
        div_cnt_reg  <= div_cnt_next;
        mul_cnt_reg  <= mul_cnt_next;
        prod_reg     <= prod_next;
        prod_neg_reg <= prod_neg_next;
        up1_acc_reg  <= up1_acc_next;
        for (int i = 0; i < 3; i++) begin
            m_reg[i]    <= m_next[i];
            rem_reg[i]  <= rem_next[i];
            q_reg[i]    <= q_next[i];
            f_reg[i]    <= f_next[i];
            up_reg[i]   <= up_next[i];
            row1_reg[i] <= row1_next[i];
        end
        for (int i = 0; i < 2; i++) begin
            row0_reg[i] <= row0_next[i];
        end
    end

`ifndef SYNTHESIS
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SQ) |-> (mx[DIFF_W-1:30] == 3'b001))
        else $error("direction not normalized before squaring");
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DSET) |-> (res_reg[63:32] == '0 && res_reg[31:30] != 2'b00))
        else $error("vector length outside [2^30, 2^32)");
    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_MUL && mul_cnt_reg == 4'd0) |->
        ((!f_mag[0][QW-1] || f_mag[0][QW-2:0] == '0) &&
         (!f_mag[1][QW-1] || f_mag[1][QW-2:0] == '0) &&
         (!f_mag[2][QW-1] || f_mag[2][QW-2:0] == '0)))
        else $error("forward component above one");
`endif

endmodule

@@ rtl/bbwm_emit.sv @@
// bbwm_emit: row buffer that hands out the four matrix rows of a job
// uses bbwm_pkg; loaded by bbwm_back, drives the result channel
module bbwm_emit
    import bbwm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  bbwm_rows_t rows_data,
    output logic       ready,
    output logic       m_valid,
    input  logic       m_ready,
    output bbwm_out_t  m_data
);

    bbwm_rows_t rows_reg;
    logic       busy_reg;
    logic [1:0] cnt_reg;

    // free once the last row is being taken
    assign ready   = !busy_reg || (m_ready && cnt_reg == ROW_POS);
    assign m_valid = busy_reg;

    always_comb begin
        m_data.row_index  = cnt_reg;
        m_data.elem_x     = rows_reg.row[cnt_reg].x;
        m_data.elem_y     = rows_reg.row[cnt_reg].y;
        m_data.elem_z     = rows_reg.row[cnt_reg].z;
        m_data.degenerate = rows_reg.degenerate;
        m_data.last       = (cnt_reg == ROW_POS);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            rows_reg <= rows_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= ROW_RIGHT;
        end else if (push) begin
            busy_reg <= 1'b1;
            cnt_reg  <= ROW_RIGHT;
        end else if (busy_reg && m_ready) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == ROW_POS) begin
                busy_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ready)
        else $error("row buffer loaded while rows still pending");
`endif

endmodule

@@ dv/tb_billboard_world_matrix.sv @@
// tb_billboard_world_matrix: self-checking testbench of the billboard world matrix block
// depends on bbwm_pkg and billboard_world_matrix; predicts four rows per transaction
module tb_billboard_world_matrix;
    import bbwm_pkg::*;

    localparam int FRAC   = 16;
    localparam int N_RAND = 380;
    localparam int WD_MAX = 20000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    bbwm_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    bbwm_out_t m_data;

    bbwm_in_t  pending_items[$];
    bbwm_out_t expected_rows[$];
    int        mismatches = 0;
    int        sent = 0;
    int        rows_seen = 0;
    int        wd_count = 0;
    bit        quiet_phase = 1'b0;
    bit        hold_sender = 1'b0;
    int        s_gap = 0;
    int        m_gap = 0;

    billboard_world_matrix #(.FRAC_BITS(FRAC)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    // ---------------- predictor ----------------

    function automatic longint round_mag(longint unsigned m);
        return longint'((m + (64'd1 << (FRAC - 1))) >> FRAC);
    endfunction

    // fixed point product, rounded, halves away from zero
    function automatic longint fx_mul(longint a, longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r = round_mag(ma * mb);
        return (((a < 0) != (b < 0)) ? -r : r);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // unit vector along a nonzero direction
    task automatic unit_dir(input longint d[3], output longint f[3]);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned acc;
        longint unsigned len;
        longint unsigned q;
        mx = 0;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (d[i] < 0) ? -d[i] : d[i];
            if (m[i] > mx) mx = m[i];
        end
        while (mx >= (64'd1 << 31)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 30)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) acc += m[i] * m[i];
        len = int_sqrt(acc);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC) + (len >> 1)) / len;
            f[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
        end
    endtask

    // queue the four matrix rows that one billboard produces
    task automatic predict_rows(input bbwm_in_t it);
        longint    d[3];
        longint    f[3];
        longint    rt[3];
        longint    up[3];
        longint    p[3];
        longint    fa;
        longint    fz;
        logic      degen;
        bbwm_out_t r;
        degen = 1'b0;
        p[0] = it.billboard_x;
        p[1] = it.billboard_y;
        p[2] = it.billboard_z;
        d[0] = longint'(it.cam_x) - p[0];
        d[1] = longint'(it.cam_y) - p[1];
        d[2] = longint'(it.cam_z) - p[2];
        if (!it.mode) begin
            d[1] = 0;
            if (d[0] == 0 && d[2] == 0) begin
                // straight overhead: face along +z
                f[0] = 0; f[1] = 0; f[2] = 64'sd1 << FRAC;
            end else begin
                unit_dir(d, f);
            end
        end else if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
            degen = 1'b1;
            f[0] = 0; f[1] = 0; f[2] = 0;
        end else begin
            unit_dir(d, f);
        end
        rt[0] = f[2];
        rt[1] = 0;
        rt[2] = -f[0];
        fa = (f[0] < 0) ? -f[0] : f[0];
        fz = (f[2] < 0) ? -f[2] : f[2];
        up[0] = -fx_mul(f[0], f[1]);
        up[1] = round_mag(fa * fa + fz * fz);
        up[2] = -fx_mul(f[1], f[2]);
        for (int k = 0; k < 4; k++) begin
            r.row_index  = k[1:0];
            r.degenerate = degen;
            r.last       = (k == 3);
            case (k)
                0: begin
                    r.elem_x = clamp32(fx_mul(it.scale_x, rt[0]));
                    r.elem_y = clamp32(fx_mul(it.scale_x, rt[1]));
                    r.elem_z = clamp32(fx_mul(it.scale_x, rt[2]));
                end
                1: begin
                    r.elem_x = clamp32(fx_mul(it.scale_y, up[0]));
                    r.elem_y = clamp32(fx_mul(it.scale_y, up[1]));
                    r.elem_z = clamp32(fx_mul(it.scale_y, up[2]));
                end
                2: begin
                    r.elem_x = clamp32(-f[0]);
                    r.elem_y = clamp32(-f[1]);
                    r.elem_z = clamp32(-f[2]);
                end
                default: begin
                    r.elem_x = it.billboard_x;
                    r.elem_y = it.billboard_y;
                    r.elem_z = it.billboard_z;
                end
            endcase
            expected_rows.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("row %0d: %s got %h expected %h", rows_seen, what, got, want);
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h80000000 | $urandom_range(0, 3);
            2: return 32'h7fffffff - $urandom_range(0, 3);
            3: return $urandom_range(0, 8) - 4;
            default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
        endcase
    endfunction

    function automatic bbwm_in_t rnd_item();
        bbwm_in_t it;
        it.mode        = 1'($urandom_range(0, 1));
        it.billboard_x = rnd_word();
        it.billboard_y = rnd_word();
        it.billboard_z = rnd_word();
        it.cam_x = it.billboard_x + rnd_word();
        it.cam_y = it.billboard_y + rnd_word();
        it.cam_z = it.billboard_z + rnd_word();
        // sometimes share components to hit zero and axis-aligned directions
        if ($urandom_range(0, 5) == 0) it.cam_x = it.billboard_x;
        if ($urandom_range(0, 5) == 0) it.cam_y = it.billboard_y;
        if ($urandom_range(0, 5) == 0) it.cam_z = it.billboard_z;
        it.scale_x = rnd_word();
        it.scale_y = rnd_word();
        return it;
    endfunction

    function automatic bbwm_in_t mk(logic m, logic [31:0] cx, logic [31:0] cy,
                                    logic [31:0] cz, logic [31:0] bx, logic [31:0] by,
                                    logic [31:0] bz, logic [31:0] sx, logic [31:0] sy);
        bbwm_in_t it;
        it = '{m, cx, cy, cz, bx, by, bz, sx, sy};
        return it;
    endfunction

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_rows(s_data);
                sent++;
            end
            if (!(s_valid && !s_ready)) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                    s_gap <= $urandom_range(1, 11);
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0 && !hold_sender) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        bbwm_out_t w;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) wd_count <= 0;
            else wd_count <= wd_count + 1;
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch("unexpected row", 32'(m_data.row_index), 32'd0);
                end else begin
                    w = expected_rows.pop_front();
                    if (m_data.row_index != w.row_index)
                        report_mismatch("row_index", 32'(m_data.row_index), 32'(w.row_index));
                    if (m_data.elem_x != w.elem_x)
                        report_mismatch("elem_x", m_data.elem_x, w.elem_x);
                    if (m_data.elem_y != w.elem_y)
                        report_mismatch("elem_y", m_data.elem_y, w.elem_y);
                    if (m_data.elem_z != w.elem_z)
                        report_mismatch("elem_z", m_data.elem_z, w.elem_z);
                    if (m_data.degenerate != w.degenerate)
                        report_mismatch("degenerate", 32'(m_data.degenerate),
                                        32'(w.degenerate));
                    if (m_data.last != w.last)
                        report_mismatch("last", 32'(m_data.last), 32'(w.last));
                end
                rows_seen++;
            end
            // receiver stalls in bursts
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
                m_gap <= $urandom_range(1, 11);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: nothing accepted for too long
    always @(posedge aclk) begin
        if (wd_count >= WD_MAX) begin
            $display("timeout, %0d rows outstanding", expected_rows.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        // directed: extremes and each special case
        pending_items.push_back(mk(0, 32'd5, 32'd9, 32'd5, 32'd5, 32'd1, 32'd5,
                                   32'h10000, 32'h10000));            // overhead, cylindrical
        pending_items.push_back(mk(1, 32'd7, 32'd7, 32'd7, 32'd7, 32'd7, 32'd7,
                                   32'h20000, 32'h30000));            // zero length, facing
        pending_items.push_back(mk(1, 32'd0, 32'h50000, 32'd0, 32'd0, 32'd0, 32'd0,
                                   32'h10000, 32'h10000));            // straight up, facing
        pending_items.push_back(mk(1, 32'd0, 32'h80000000, 32'd0, 32'd0, 32'h7fffffff,
                                   32'd0, 32'h10000, 32'h10000));     // straight down, max
        pending_items.push_back(mk(0, 32'h80000000, 32'd0, 32'd0, 32'h7fffffff, 32'd0,
                                   32'd0, 32'h80000000, 32'h80000000)); // most negative scales
        pending_items.push_back(mk(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                   32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7fffffff, 32'h7fffffff));
        pending_items.push_back(mk(1, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                   32'hffffffff, 32'h80000000));
        pending_items.push_back(mk(0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                   32'hffff0000, 32'h10000));         // tiny direction
        pending_items.push_back(mk(1, 32'd0, 32'd0, 32'hffffffff, 32'd0, 32'd0, 32'd0,
                                   32'h10000, 32'h10000));
        pending_items.push_back(mk(1, 32'd3, 32'd4, 32'd0, 32'd0, 32'd0, 32'd0,
                                   32'd0, 32'd0));                    // zero scale
        pending_items.push_back(mk(0, 32'h12345678, 32'hdeadbeef, 32'h9abcdef0,
                                   32'h0, 32'h0, 32'h0, 32'h00018000, 32'hfffe8000));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // pause the sender until everything directed has drained
        wait (pending_items.size() == 0);
        hold_sender = 1'b1;
        @(posedge aclk);
        wait (expected_rows.size() == 0 && !s_valid);
        hold_sender = 1'b0;

        for (int n = 0; n < N_RAND; n++) pending_items.push_back(rnd_item());
        wait (pending_items.size() < 40);
        quiet_phase = 1'b1;
        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_rows.size() == 0);
        repeat (100) @(posedge aclk);

        $display("%0d billboards sent, %0d matrix rows checked, both modes and edge cases",
                 sent, rows_seen);
        if (mismatches == 0 && expected_rows.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
